FILE: hw/rtl/vpu_pkg.sv
package vpu_pkg;

    localparam int POS_FRAC_BITS = 22;
    localparam int BOX_BITS      = 10;
    localparam int POS_BITS      = BOX_BITS + POS_FRAC_BITS;
    localparam int DISP_BITS     = 48;
    localparam int ANGLE_BITS    = 16;
    localparam int NOISE_BITS    = 16;
    localparam int Q15_BITS      = 16;
    localparam int STEP_BITS     = POS_FRAC_BITS + 2;

    // octant reduction and table split of the reduced angle
    localparam int OCT_BITS = ANGLE_BITS - 2;
    localparam int LO_BITS  = 6;
    localparam int HI_BITS  = OCT_BITS - LO_BITS;

    // fixed-point formats of the trig tables
    localparam int TRIG_FRAC = 48;
    localparam int TAB_BITS  = TRIG_FRAC + 1;
    localparam int NARROW    = 32;
    localparam int NARROW_SH = TAB_BITS - NARROW;
    localparam int SL_FRAC   = 39;
    localparam int DL_FRAC   = 47;
    localparam int SL_SH     = (TRIG_FRAC - NARROW_SH) - (TRIG_FRAC - SL_FRAC);
    localparam int DL_SH     = (TRIG_FRAC - NARROW_SH) - (TRIG_FRAC - DL_FRAC);
    localparam int ACC_BITS  = TAB_BITS + 1;
    localparam int RND_BITS  = ACC_BITS + 16;

    localparam int QUEUE_DEPTH = 4;

    localparam int CFG_INDEX_BITS = 8;
    localparam int CFG_DATA_BITS  = 22;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEP_LENGTH    = 8'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_NOISE_STRENGTH = 8'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_WIDTH      = 8'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BOX_HEIGHT     = 8'd3;

    localparam logic [POS_FRAC_BITS-1:0] STEP_LENGTH_RST    = 22'd6291;
    localparam logic [NOISE_BITS-1:0]    NOISE_STRENGTH_RST = 16'd1311;
    localparam logic [BOX_BITS-1:0]      BOX_WIDTH_RST      = 10'd12;
    localparam logic [BOX_BITS-1:0]      BOX_HEIGHT_RST     = 10'd12;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;
    localparam logic [1:0] QUAD_FOURTH = 2'd3;

    localparam real PI = 3.14159265358979323846;

    // radians per binary angle unit
    localparam real ANG_UNIT = PI / 2.0**(ANGLE_BITS-1);

    typedef logic [TAB_BITS-1:0] hi_tab_t [2**HI_BITS];
    typedef logic [NARROW-1:0]   lo_tab_t [2**LO_BITS];

    typedef struct packed {
        logic [POS_FRAC_BITS-1:0] step_length;
        logic [NOISE_BITS-1:0]    noise_strength;
        logic [BOX_BITS-1:0]      box_width;
        logic [BOX_BITS-1:0]      box_height;
    } cfg_t;

    typedef struct packed {
        logic [POS_BITS-1:0]         pos_x;
        logic [POS_BITS-1:0]         pos_y;
        logic signed [DISP_BITS-1:0] disp_x;
        logic signed [DISP_BITS-1:0] disp_y;
        logic [ANGLE_BITS-1:0]       new_heading;
        logic [ANGLE_BITS-1:0]       turn;
    } rec_t;

    typedef struct packed {
        rec_t               rec;
        logic [1:0]         quad;
        logic               swap;
        logic [HI_BITS-1:0] hi;
        logic [LO_BITS-1:0] lo;
    } item_t;

    function automatic hi_tab_t build_cos_tab();
        hi_tab_t t;
        real a;
        for (int h = 0; h < 2**HI_BITS; h++)
        begin
            a = real'(h) * real'(2**LO_BITS) * ANG_UNIT;
            t[h] = (h <= 2**(HI_BITS-1)) ?
                   TAB_BITS'(longint'($cos(a) * 2.0**TRIG_FRAC)) : '0;
        end
        return t;
    endfunction

    function automatic hi_tab_t build_sin_tab();
        hi_tab_t t;
        real a;
        for (int h = 0; h < 2**HI_BITS; h++)
        begin
            a = real'(h) * real'(2**LO_BITS) * ANG_UNIT;
            t[h] = (h <= 2**(HI_BITS-1)) ?
                   TAB_BITS'(longint'($sin(a) * 2.0**TRIG_FRAC)) : '0;
        end
        return t;
    endfunction

    function automatic lo_tab_t build_sl_tab();
        lo_tab_t t;
        real a;
        for (int l = 0; l < 2**LO_BITS; l++)
        begin
            a = real'(l) * ANG_UNIT;
            t[l] = NARROW'(longint'($sin(a) * 2.0**SL_FRAC));
        end
        return t;
    endfunction

    // 1 - cos, formed as 2 sin^2 of the half angle to keep precision
    function automatic lo_tab_t build_dl_tab();
        lo_tab_t t;
        real a;
        for (int l = 0; l < 2**LO_BITS; l++)
        begin
            a = real'(l) * ANG_UNIT;
            t[l] = NARROW'(longint'(2.0 * $sin(a * 0.5) * $sin(a * 0.5) * 2.0**DL_FRAC));
        end
        return t;
    endfunction

    localparam hi_tab_t COS_HI_TAB = build_cos_tab();
    localparam hi_tab_t SIN_HI_TAB = build_sin_tab();
    localparam lo_tab_t SIN_LO_TAB = build_sl_tab();
    localparam lo_tab_t DEV_LO_TAB = build_dl_tab();

endpackage

FILE: hw/rtl/vpu_front.sv
module vpu_front
(
    input  logic [vpu_pkg::NOISE_BITS-1:0]        noise_strength,
    input  logic [vpu_pkg::POS_BITS-1:0]          pos_x,
    input  logic [vpu_pkg::POS_BITS-1:0]          pos_y,
    input  logic signed [vpu_pkg::DISP_BITS-1:0]  disp_x,
    input  logic signed [vpu_pkg::DISP_BITS-1:0]  disp_y,
    input  logic signed [vpu_pkg::ANGLE_BITS-1:0] heading,
    input  logic signed [vpu_pkg::ANGLE_BITS-1:0] neighbour_heading,
    input  logic [vpu_pkg::NOISE_BITS-1:0]        noise_sample,
    output vpu_pkg::item_t                        item
);

    logic signed [vpu_pkg::NOISE_BITS-1:0]   centered;
    logic signed [vpu_pkg::NOISE_BITS:0]     strength;
    logic signed [2*vpu_pkg::NOISE_BITS:0]   prod;
    logic [vpu_pkg::ANGLE_BITS-1:0]          noise;
    logic [vpu_pkg::ANGLE_BITS-1:0]          new_h;
    logic [vpu_pkg::OCT_BITS-1:0]            r;
    logic [vpu_pkg::OCT_BITS-1:0]            rr;
    logic                                    swap;

    // sample minus one half is the sample with its top bit flipped
    assign centered = signed'(noise_sample ^ {1'b1, {(vpu_pkg::NOISE_BITS-1){1'b0}}});
    assign strength = signed'({1'b0, noise_strength});
    assign prod     = strength * centered;
    assign noise    = prod[2*vpu_pkg::NOISE_BITS-vpu_pkg::ANGLE_BITS +: vpu_pkg::ANGLE_BITS];
    assign new_h    = neighbour_heading + noise;

    // fold into the first octant; mirror about the eighth turn
    assign r    = new_h[vpu_pkg::OCT_BITS-1:0];
    assign swap = r > vpu_pkg::OCT_BITS'(2**(vpu_pkg::OCT_BITS-1));
    assign rr   = swap ? vpu_pkg::OCT_BITS'(-r) : r;

    always_comb
    begin
        item.rec.pos_x       = pos_x;
        item.rec.pos_y       = pos_y;
        item.rec.disp_x      = disp_x;
        item.rec.disp_y      = disp_y;
        item.rec.new_heading = new_h;
        item.rec.turn        = new_h - heading;
        item.quad            = new_h[vpu_pkg::ANGLE_BITS-1 -: 2];
        item.swap            = swap;
        item.hi              = rr[vpu_pkg::OCT_BITS-1 -: vpu_pkg::HI_BITS];
        item.lo              = rr[vpu_pkg::LO_BITS-1:0];
    end

endmodule

FILE: hw/rtl/vpu_queue.sv
module vpu_queue
#(
    parameter int DEPTH = vpu_pkg::QUEUE_DEPTH
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    input  vpu_pkg::item_t               wr_item,
    input  logic                         pop,
    output vpu_pkg::item_t               head,
    output logic                         nonempty,
    output logic                         full,
    output logic [$clog2(DEPTH+1)-1:0]   count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    vpu_pkg::item_t    slot_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CW'(push) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    assign head     = slot_reg[rd_ptr_reg];
    assign nonempty = count_reg != '0;
    assign full     = count_reg == CW'(DEPTH);
    assign count    = count_reg;

endmodule

FILE: hw/rtl/vpu_back.sv
module vpu_back
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  vpu_pkg::cfg_t                         cfg,
    input  vpu_pkg::item_t                        head,
    input  logic                                  nonempty,
    output logic                                  pop,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [vpu_pkg::POS_BITS-1:0]          new_pos_x,
    output logic [vpu_pkg::POS_BITS-1:0]          new_pos_y,
    output logic signed [vpu_pkg::DISP_BITS-1:0]  new_disp_x,
    output logic signed [vpu_pkg::DISP_BITS-1:0]  new_disp_y,
    output logic signed [vpu_pkg::ANGLE_BITS-1:0] new_heading,
    output logic signed [vpu_pkg::ANGLE_BITS-1:0] turn,
    output logic signed [vpu_pkg::Q15_BITS-1:0]   cos_heading,
    output logic signed [vpu_pkg::Q15_BITS-1:0]   sin_heading
);

    localparam int TB = vpu_pkg::TAB_BITS;
    localparam int NB = vpu_pkg::NARROW;
    localparam int AB = vpu_pkg::ACC_BITS;
    localparam int RB = vpu_pkg::RND_BITS;
    localparam int QB = vpu_pkg::Q15_BITS;
    localparam int SB = vpu_pkg::STEP_BITS;
    localparam int FB = vpu_pkg::POS_FRAC_BITS;
    localparam int PB = vpu_pkg::POS_BITS;
    localparam int DB = vpu_pkg::DISP_BITS;
    localparam int MB = FB + 1 + QB;
    localparam int XB = PB + 2;
    localparam int VB = DB + 2;

    logic adv;

    // stage 1: table read
    logic              v1_reg, v1_next;
    vpu_pkg::rec_t     rec1_reg, rec1_next;
    logic [1:0]        quad1_reg, quad1_next;
    logic              swap1_reg, swap1_next;
    logic [TB-1:0]     ch1_reg, ch1_next, sh1_reg, sh1_next;
    logic [NB-1:0]     sl1_reg, sl1_next, dl1_reg, dl1_next;

    // stage 2: partial products
    logic              v2_reg, v2_next;
    vpu_pkg::rec_t     rec2_reg, rec2_next;
    logic [1:0]        quad2_reg, quad2_next;
    logic              swap2_reg, swap2_next;
    logic [TB-1:0]     ch2_reg, ch2_next, sh2_reg, sh2_next;
    logic [2*NB-1:0]   pcd_reg, pcd_next, pss_reg, pss_next;
    logic [2*NB-1:0]   psd_reg, psd_next, pcs_reg, pcs_next;

    // stage 3: octant cos and sin, Q48
    logic              v3_reg, v3_next;
    vpu_pkg::rec_t     rec3_reg, rec3_next;
    logic [1:0]        quad3_reg, quad3_next;
    logic              swap3_reg, swap3_next;
    logic signed [AB-1:0] co3_reg, co3_next, so3_reg, so3_next;

    // stage 4: rounded Q1.15, full circle
    logic              v4_reg, v4_next;
    vpu_pkg::rec_t     rec4_reg, rec4_next;
    logic signed [QB-1:0] c4_reg, c4_next, s4_reg, s4_next;

    // stage 5: step along the heading
    logic              v5_reg, v5_next;
    vpu_pkg::rec_t     rec5_reg, rec5_next;
    logic signed [QB-1:0] c5_reg, c5_next, s5_reg, s5_next;
    logic signed [SB-1:0] stx5_reg, stx5_next, sty5_reg, sty5_next;

    // stage 6: output register
    logic              out_valid_reg, out_valid_next;
    vpu_pkg::rec_t     rec6_reg, rec6_next;
    logic signed [QB-1:0] c6_reg, c6_next, s6_reg, s6_next;

    logic signed [RB-1:0] rc, rs;
    logic signed [QB-1:0] oc, os;
    logic signed [MB-1:0] mx, my;
    logic signed [FB:0]   slen;

    // whole back end moves unless a result is held at the output
    assign adv = !out_valid_reg || !out_stall;
    assign pop = adv && nonempty;

    function automatic logic [PB-1:0] move_pos(logic [PB-1:0] pos,
                                               logic signed [SB-1:0] step,
                                               logic [vpu_pkg::BOX_BITS-1:0] cells);
        logic signed [XB-1:0] x;
        logic signed [XB-1:0] lim;
        logic signed [XB-1:0] r;
        x   = signed'({2'b00, pos}) + XB'(step);
        lim = signed'({2'b00, cells, {FB{1'b0}}});
        if (x >= lim)
        begin
            r = x - lim;
        end
        else if (x < 0)
        begin
            r = x + lim;
        end
        else
        begin
            r = x;
        end
        return r[PB-1:0];
    endfunction

    function automatic logic signed [DB-1:0] move_disp(logic signed [DB-1:0] d,
                                                       logic signed [SB-1:0] step);
        logic signed [VB-1:0] v;
        logic signed [VB-1:0] maxv;
        logic signed [VB-1:0] minv;
        logic signed [DB-1:0] r;
        maxv = signed'(VB'({1'b0, {(DB-1){1'b1}}}));
        minv = -maxv - signed'(VB'(1));
        v = VB'(d) + VB'(step);
        if (v > maxv)
        begin
            r = {1'b0, {(DB-1){1'b1}}};
        end
        else if (v < minv)
        begin
            r = {1'b1, {(DB-1){1'b0}}};
        end
        else
        begin
            r = v[DB-1:0];
        end
        return r;
    endfunction

    always_comb
    begin
        v1_next    = pop;
        rec1_next  = head.rec;
        quad1_next = head.quad;
        swap1_next = head.swap;
        ch1_next   = vpu_pkg::COS_HI_TAB[head.hi];
        sh1_next   = vpu_pkg::SIN_HI_TAB[head.hi];
        sl1_next   = vpu_pkg::SIN_LO_TAB[head.lo];
        dl1_next   = vpu_pkg::DEV_LO_TAB[head.lo];

        v2_next    = v1_reg;
        rec2_next  = rec1_reg;
        quad2_next = quad1_reg;
        swap2_next = swap1_reg;
        ch2_next   = ch1_reg;
        sh2_next   = sh1_reg;
        pcd_next   = ch1_reg[TB-1 -: NB] * dl1_reg;
        pss_next   = sh1_reg[TB-1 -: NB] * sl1_reg;
        psd_next   = sh1_reg[TB-1 -: NB] * dl1_reg;
        pcs_next   = ch1_reg[TB-1 -: NB] * sl1_reg;

        // cos(h+l) = Ch - Ch(1-cos l) - Sh sin l, sin likewise
        v3_next    = v2_reg;
        rec3_next  = rec2_reg;
        quad3_next = quad2_reg;
        swap3_next = swap2_reg;
        co3_next   = signed'(AB'(ch2_reg)) - signed'(AB'(pcd_reg >> vpu_pkg::DL_SH))
                     - signed'(AB'(pss_reg >> vpu_pkg::SL_SH));
        so3_next   = signed'(AB'(sh2_reg)) - signed'(AB'(psd_reg >> vpu_pkg::DL_SH))
                     + signed'(AB'(pcs_reg >> vpu_pkg::SL_SH));

        // round(32767 v) as (v*2^15 - v + half) >> 48
        rc = (RB'(co3_reg) <<< 15) - RB'(co3_reg)
             + (RB'(1) <<< (vpu_pkg::TRIG_FRAC - 1));
        rs = (RB'(so3_reg) <<< 15) - RB'(so3_reg)
             + (RB'(1) <<< (vpu_pkg::TRIG_FRAC - 1));
        oc = swap3_reg ? rs[vpu_pkg::TRIG_FRAC +: QB] : rc[vpu_pkg::TRIG_FRAC +: QB];
        os = swap3_reg ? rc[vpu_pkg::TRIG_FRAC +: QB] : rs[vpu_pkg::TRIG_FRAC +: QB];
        v4_next   = v3_reg;
        rec4_next = rec3_reg;
        case (quad3_reg)
            vpu_pkg::QUAD_FIRST:
            begin
                c4_next = oc;
                s4_next = os;
            end
            vpu_pkg::QUAD_SECOND:
            begin
                c4_next = -os;
                s4_next = oc;
            end
            vpu_pkg::QUAD_THIRD:
            begin
                c4_next = -oc;
                s4_next = -os;
            end
            default:
            begin
                c4_next = os;
                s4_next = -oc;
            end
        endcase

        slen      = signed'({1'b0, cfg.step_length});
        mx        = slen * c4_reg;
        my        = slen * s4_reg;
        v5_next   = v4_reg;
        rec5_next = rec4_reg;
        c5_next   = c4_reg;
        s5_next   = s4_reg;
        stx5_next = SB'(mx >>> 15);
        sty5_next = SB'(my >>> 15);

        out_valid_next        = v5_reg;
        rec6_next             = rec5_reg;
        rec6_next.pos_x       = move_pos(rec5_reg.pos_x, stx5_reg, cfg.box_width);
        rec6_next.pos_y       = move_pos(rec5_reg.pos_y, sty5_reg, cfg.box_height);
        rec6_next.disp_x      = move_disp(rec5_reg.disp_x, stx5_reg);
        rec6_next.disp_y      = move_disp(rec5_reg.disp_y, sty5_reg);
        c6_next               = c5_reg;
        s6_next               = s5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            v4_reg        <= v4_next;
            v5_reg        <= v5_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rec1_reg  <= rec1_next;
            quad1_reg <= quad1_next;
            swap1_reg <= swap1_next;
            ch1_reg   <= ch1_next;
            sh1_reg   <= sh1_next;
            sl1_reg   <= sl1_next;
            dl1_reg   <= dl1_next;
            rec2_reg  <= rec2_next;
            quad2_reg <= quad2_next;
            swap2_reg <= swap2_next;
            ch2_reg   <= ch2_next;
            sh2_reg   <= sh2_next;
            pcd_reg   <= pcd_next;
            pss_reg   <= pss_next;
            psd_reg   <= psd_next;
            pcs_reg   <= pcs_next;
            rec3_reg  <= rec3_next;
            quad3_reg <= quad3_next;
            swap3_reg <= swap3_next;
            co3_reg   <= co3_next;
            so3_reg   <= so3_next;
            rec4_reg  <= rec4_next;
            c4_reg    <= c4_next;
            s4_reg    <= s4_next;
            rec5_reg  <= rec5_next;
            c5_reg    <= c5_next;
            s5_reg    <= s5_next;
            stx5_reg  <= stx5_next;
            sty5_reg  <= sty5_next;
            rec6_reg  <= rec6_next;
            c6_reg    <= c6_next;
            s6_reg    <= s6_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_pos_x   = rec6_reg.pos_x;
    assign new_pos_y   = rec6_reg.pos_y;
    assign new_disp_x  = rec6_reg.disp_x;
    assign new_disp_y  = rec6_reg.disp_y;
    assign new_heading = signed'(rec6_reg.new_heading);
    assign turn        = signed'(rec6_reg.turn);
    assign cos_heading = c6_reg;
    assign sin_heading = s6_reg;

endmodule

FILE: hw/rtl/vicsek_particle_update.sv
// Vicsek particle update. Takes one particle record per cycle while in_stall is low and returns the
// updated record (new heading with noise, turn, cos/sin in Q1.15, wrapped position, saturated
// displacement): the input transfer writes the input queue, and the queue is read into the first
// of six back pipeline stages, paced by the table lookup, the 32x32 angle-addition products and
// the step multiplier. Sustained rate is one item per cycle while the output is not stalled. The
// input queue holds QUEUE_DEPTH items, so input keeps flowing until it fills while the output is
// stalled. Configuration writes are taken every cycle and
// must only be issued while the block is empty.
module vicsek_particle_update
#(
    parameter int QUEUE_DEPTH = vpu_pkg::QUEUE_DEPTH
)
(
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [vpu_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [vpu_pkg::CFG_DATA_BITS-1:0]         cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [vpu_pkg::POS_BITS-1:0]              pos_x,
    input  logic [vpu_pkg::POS_BITS-1:0]              pos_y,
    input  logic signed [vpu_pkg::DISP_BITS-1:0]      disp_x,
    input  logic signed [vpu_pkg::DISP_BITS-1:0]      disp_y,
    input  logic signed [vpu_pkg::ANGLE_BITS-1:0]     heading,
    input  logic signed [vpu_pkg::ANGLE_BITS-1:0]     neighbour_heading,
    input  logic [vpu_pkg::NOISE_BITS-1:0]            noise_sample,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic [vpu_pkg::POS_BITS-1:0]              new_pos_x,
    output logic [vpu_pkg::POS_BITS-1:0]              new_pos_y,
    output logic signed [vpu_pkg::DISP_BITS-1:0]      new_disp_x,
    output logic signed [vpu_pkg::DISP_BITS-1:0]      new_disp_y,
    output logic signed [vpu_pkg::ANGLE_BITS-1:0]     new_heading,
    output logic signed [vpu_pkg::ANGLE_BITS-1:0]     turn,
    output logic signed [vpu_pkg::Q15_BITS-1:0]       cos_heading,
    output logic signed [vpu_pkg::Q15_BITS-1:0]       sin_heading
);

    localparam int CW = $clog2(QUEUE_DEPTH+1);

    vpu_pkg::cfg_t   cfg_reg, cfg_next;
    vpu_pkg::item_t  front_item;
    vpu_pkg::item_t  head;
    logic            push;
    logic            pop;
    logic            nonempty;
    logic            full;
    logic [CW-1:0]   count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                vpu_pkg::CFG_STEP_LENGTH:
                    cfg_next.step_length = cfg_data[vpu_pkg::POS_FRAC_BITS-1:0];
                vpu_pkg::CFG_NOISE_STRENGTH:
                    cfg_next.noise_strength = cfg_data[vpu_pkg::NOISE_BITS-1:0];
                vpu_pkg::CFG_BOX_WIDTH:
                    cfg_next.box_width = cfg_data[vpu_pkg::BOX_BITS-1:0];
                vpu_pkg::CFG_BOX_HEIGHT:
                    cfg_next.box_height = cfg_data[vpu_pkg::BOX_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_length    <= vpu_pkg::STEP_LENGTH_RST;
            cfg_reg.noise_strength <= vpu_pkg::NOISE_STRENGTH_RST;
            cfg_reg.box_width      <= vpu_pkg::BOX_WIDTH_RST;
            cfg_reg.box_height     <= vpu_pkg::BOX_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    vpu_front u_front
    (
        .noise_strength    (cfg_reg.noise_strength),
        .pos_x             (pos_x),
        .pos_y             (pos_y),
        .disp_x            (disp_x),
        .disp_y            (disp_y),
        .heading           (heading),
        .neighbour_heading (neighbour_heading),
        .noise_sample      (noise_sample),
        .item              (front_item)
    );

    assign in_stall = full;
    assign push     = in_valid && !full;

    vpu_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (front_item),
        .pop      (pop),
        .head     (head),
        .nonempty (nonempty),
        .full     (full),
        .count    (count)
    );

    vpu_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .head        (head),
        .nonempty    (nonempty),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .new_pos_x   (new_pos_x),
        .new_pos_y   (new_pos_y),
        .new_disp_x  (new_disp_x),
        .new_disp_y  (new_disp_y),
        .new_heading (new_heading),
        .turn        (turn),
        .cos_heading (cos_heading),
        .sin_heading (sin_heading)
    );

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= CW'(QUEUE_DEPTH))
        else $error("input queue over capacity");

    a_queue_count: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> count == $past(count) + CW'($past(push)) - CW'($past(pop)))
        else $error("queue count lost track of transfers");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> nonempty)
        else $error("pop from empty queue");

    a_trig_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cos_heading != 16'sh8000 && sin_heading != 16'sh8000)
        else $error("cos or sin out of Q1.15 range");
`endif

endmodule

FILE: tb/vicsek_particle_update_test.sv
`timescale 1ns / 100ps

module vicsek_particle_update_test;

    import vpu_pkg::*;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RAND_PER_PHASE = 200;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 8'd9;
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q60 = 64'h1000000000000000;

    typedef struct {
        logic [POS_BITS-1:0]         px;
        logic [POS_BITS-1:0]         py;
        logic signed [DISP_BITS-1:0] dx;
        logic signed [DISP_BITS-1:0] dy;
        logic signed [ANGLE_BITS-1:0] hd;
        logic signed [ANGLE_BITS-1:0] nh;
        logic [NOISE_BITS-1:0]       ns;
    } particle_t;

    typedef struct {
        logic [POS_BITS-1:0]         px;
        logic [POS_BITS-1:0]         py;
        logic signed [DISP_BITS-1:0] dx;
        logic signed [DISP_BITS-1:0] dy;
        logic signed [ANGLE_BITS-1:0] h;
        logic signed [ANGLE_BITS-1:0] t;
        logic signed [Q15_BITS-1:0]  c;
        logic signed [Q15_BITS-1:0]  s;
    } update_t;

    class update_scoreboard;
        logic [POS_FRAC_BITS-1:0] step_length;
        logic [NOISE_BITS-1:0]    noise_strength;
        logic [BOX_BITS-1:0]      box_width;
        logic [BOX_BITS-1:0]      box_height;
        update_t expected_q[$];
        int errors;
        int checked;

        function new();
            step_length = STEP_LENGTH_RST;
            noise_strength = NOISE_STRENGTH_RST;
            box_width = BOX_WIDTH_RST;
            box_height = BOX_HEIGHT_RST;
            errors = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] d);
            case (idx)
                CFG_STEP_LENGTH:    step_length = d[POS_FRAC_BITS-1:0];
                CFG_NOISE_STRENGTH: noise_strength = d[NOISE_BITS-1:0];
                CFG_BOX_WIDTH:      box_width = d[BOX_BITS-1:0];
                CFG_BOX_HEIGHT:     box_height = d[BOX_BITS-1:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return p[123:60];
        endfunction

        function int round_q15(logic [63:0] v);
            logic [127:0] p;
            p = {64'd0, v} * 128'd32767 + (128'd1 << 59);
            return int'(p[123:60]);
        endfunction

        // series cos/sin of an angle in the first octant
        function void octant_trig(logic [63:0] r, output int c, output int s);
            logic [127:0] p;
            logic [63:0] x, x2, tc, ts, sc, ss;
            p = {64'd0, r} * {64'd0, PI_Q60};
            x = p[78:15];
            x2 = mul_q60(x, x);
            tc = ONE_Q60;
            sc = ONE_Q60;
            ts = x;
            ss = x;
            for (int k = 1; k <= 12; k++)
            begin
                tc = mul_q60(tc, x2) / 64'((2 * k - 1) * (2 * k));
                ts = mul_q60(ts, x2) / 64'((2 * k) * (2 * k + 1));
                if (k % 2 == 1)
                begin
                    sc = sc - tc;
                    ss = ss - ts;
                end
                else
                begin
                    sc = sc + tc;
                    ss = ss + ts;
                end
            end
            c = round_q15(sc);
            s = round_q15(ss);
        endfunction

        function void heading_trig(logic [ANGLE_BITS-1:0] a, output int c, output int s);
            logic [13:0] r;
            int cr, sr, t;
            r = a[13:0];
            if (r > 14'd8192)
                octant_trig(64'(16384 - int'(r)), sr, cr);
            else
                octant_trig(64'(r), cr, sr);
            case (a[15:14])
                QUAD_FIRST: ;
                QUAD_SECOND:
                begin
                    t = cr;
                    cr = -sr;
                    sr = t;
                end
                QUAD_THIRD:
                begin
                    cr = -cr;
                    sr = -sr;
                end
                default:
                begin
                    t = cr;
                    cr = sr;
                    sr = -t;
                end
            endcase
            c = cr;
            s = sr;
        endfunction

        function logic [POS_BITS-1:0] wrap_pos(logic [POS_BITS-1:0] pos, longint st,
                                               logic [BOX_BITS-1:0] cells);
            longint x, lim;
            x = longint'(pos) + st;
            lim = longint'(cells) <<< POS_FRAC_BITS;
            if (x >= lim)
                x = x - lim;
            else if (x < 0)
                x = x + lim;
            return x[POS_BITS-1:0];
        endfunction

        function logic [DISP_BITS-1:0] sat_disp(logic signed [DISP_BITS-1:0] d, longint st);
            longint v, maxv, minv;
            maxv = (longint'(1) <<< (DISP_BITS - 1)) - 1;
            minv = -maxv - 1;
            v = longint'(d) + st;
            if (v > maxv)
                v = maxv;
            if (v < minv)
                v = minv;
            return v[DISP_BITS-1:0];
        endfunction

        function update_t predict(particle_t p);
            update_t u;
            longint smp, noise, stx, sty;
            int c, s;
            smp = longint'(p.ns) - 32768;
            noise = (longint'(noise_strength) * smp) >>> 16;
            u.h = p.nh + 16'(noise);
            u.t = u.h - p.hd;
            heading_trig(u.h, c, s);
            u.c = 16'(c);
            u.s = 16'(s);
            stx = (longint'(step_length) * c) >>> 15;
            sty = (longint'(step_length) * s) >>> 15;
            u.px = wrap_pos(p.px, stx, box_width);
            u.py = wrap_pos(p.py, sty, box_height);
            u.dx = sat_disp(p.dx, stx);
            u.dy = sat_disp(p.dy, sty);
            return u;
        endfunction

        function void note_input(particle_t p);
            expected_q.insert(expected_q.size(), predict(p));
        endfunction

        function void compare(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a)
            begin
                errors++;
                $display("%0t mismatch %s expected %h actual %h", $time, name, e, a);
            end
        endfunction

        function void check_result(update_t r);
            update_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result transfer, actual heading %h", $time, r.h);
                return;
            end
            e = expected_q.pop_front();
            checked++;
            compare("new_pos_x", 64'(e.px), 64'(r.px));
            compare("new_pos_y", 64'(e.py), 64'(r.py));
            compare("new_disp_x", 64'(e.dx), 64'(r.dx));
            compare("new_disp_y", 64'(e.dy), 64'(r.dy));
            compare("new_heading", 64'(e.h), 64'(r.h));
            compare("turn", 64'(e.t), 64'(r.t));
            compare("cos_heading", 64'(e.c), 64'(r.c));
            compare("sin_heading", 64'(e.s), 64'(r.s));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [POS_BITS-1:0] pos_x = '0;
    logic [POS_BITS-1:0] pos_y = '0;
    logic signed [DISP_BITS-1:0] disp_x = '0;
    logic signed [DISP_BITS-1:0] disp_y = '0;
    logic signed [ANGLE_BITS-1:0] heading = '0;
    logic signed [ANGLE_BITS-1:0] neighbour_heading = '0;
    logic [NOISE_BITS-1:0] noise_sample = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [POS_BITS-1:0] new_pos_x;
    logic [POS_BITS-1:0] new_pos_y;
    logic signed [DISP_BITS-1:0] new_disp_x;
    logic signed [DISP_BITS-1:0] new_disp_y;
    logic signed [ANGLE_BITS-1:0] new_heading;
    logic signed [ANGLE_BITS-1:0] turn;
    logic signed [Q15_BITS-1:0] cos_heading;
    logic signed [Q15_BITS-1:0] sin_heading;

    update_scoreboard sb = new();
    bit quiet = 1'b0;
    int cycles = 0;
    int rx_hold = 0;

    vicsek_particle_update dut (.*);

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // result side: check every transfer, stall in random bursts
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result('{new_pos_x, new_pos_y, new_disp_x, new_disp_y,
                                  new_heading, turn, cos_heading, sin_heading});
            if (rx_hold > 0)
            begin
                rx_hold--;
                if (rx_hold == 0)
                    out_stall <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                rx_hold = $urandom_range(1, 18);
                out_stall <= 1'b1;
            end
        end
    end

    task automatic send(particle_t p);
        in_valid <= 1'b1;
        pos_x <= p.px;
        pos_y <= p.py;
        disp_x <= p.dx;
        disp_y <= p.dy;
        heading <= p.hd;
        neighbour_heading <= p.nh;
        noise_sample <= p.ns;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_input(p);
        if (!quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // hold valid across the writes, drop it after the last transfer
    task automatic program_regs(logic [21:0] sl, logic [15:0] nstr, logic [9:0] bw,
                                logic [9:0] bh, bit add_unused);
        logic [CFG_DATA_BITS-1:0] vals[5];
        logic [CFG_INDEX_BITS-1:0] idx[5];
        int n;
        vals[0] = sl;
        vals[1] = {6'($urandom), nstr};
        vals[2] = {12'($urandom), bw};
        vals[3] = {12'($urandom), bh};
        vals[4] = 22'($urandom);
        idx[0] = CFG_STEP_LENGTH;
        idx[1] = CFG_NOISE_STRENGTH;
        idx[2] = CFG_BOX_WIDTH;
        idx[3] = CFG_BOX_HEIGHT;
        idx[4] = CFG_UNUSED;
        n = add_unused ? 5 : 4;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            sb.write_reg(idx[i], vals[i]);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic particle_t mk(logic [31:0] px, logic [31:0] py, logic [47:0] dx,
                                     logic [47:0] dy, logic [15:0] hd, logic [15:0] nh,
                                     logic [15:0] ns);
        particle_t p;
        p.px = px;
        p.py = py;
        p.dx = dx;
        p.dy = dy;
        p.hd = hd;
        p.nh = nh;
        p.ns = ns;
        return p;
    endfunction

    function automatic logic [31:0] rand_pos(logic [9:0] cells);
        if (cells == 0 || $urandom_range(0, 7) == 0)
            return $urandom;
        return $urandom_range(0, {cells, 22'd0} - 1);
    endfunction

    function automatic logic [47:0] rand_disp();
        case ($urandom_range(0, 5))
            0: return 48'h7FFF_FFFF_FFFF - 48'($urandom_range(0, 9000000));
            1: return 48'h8000_0000_0000 + 48'($urandom_range(0, 9000000));
            2: return {$urandom, $urandom};
            default: return 48'(signed'($urandom) >>> $urandom_range(0, 31));
        endcase
    endfunction

    initial
    begin
        particle_t dir_q[$];
        logic [21:0] sl;
        logic [15:0] nstr;
        logic [9:0] bw, bh;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: edges, octant and quadrant boundaries, saturation
        dir_q.insert(dir_q.size(), mk(0, 0, 0, 0, 0, 0, 16'd32768));
        dir_q.insert(dir_q.size(), mk(50331647, 50331647, 0, 0, 0, 16'd8192, 16'd32768));
        dir_q.insert(dir_q.size(), mk(0, 0, 0, 0, 16'h8000, 16'h8000, 16'd32768));
        dir_q.insert(dir_q.size(), mk('1, '1, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                      16'h7FFF, 0, 16'hFFFF));
        dir_q.insert(dir_q.size(), mk(100, 100, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF,
                                      0, 16'd8192, 16'd32768));
        dir_q.insert(dir_q.size(), mk(100, 100, 48'h8000_0000_0000, 48'h8000_0000_0000,
                                      0, 16'hA000, 16'd32768));
        dir_q.insert(dir_q.size(), mk(12345, 54321, 0, 0, 0, 16'd8191, 16'd32768));
        dir_q.insert(dir_q.size(), mk(12345, 54321, 0, 0, 0, 16'd8193, 16'd32768));
        dir_q.insert(dir_q.size(), mk(7, 7, 0, 0, 0, 16'd16384, 16'd32768));
        dir_q.insert(dir_q.size(), mk(7, 7, 0, 0, 0, 16'hC000, 16'd32768));
        dir_q.insert(dir_q.size(), mk(7, 7, 0, 0, 0, 16'd24576, 16'd32768));
        dir_q.insert(dir_q.size(), mk(7, 7, 0, 0, 16'h7FFF, 16'h7FFF, 16'hFFFF));
        dir_q.insert(dir_q.size(), mk(7, 7, 0, 0, 16'h8000, 16'h8000, 16'd0));
        dir_q.insert(dir_q.size(), mk(50331648, 0, 48'hFFFF_FFFF_FFFF, 0, 16'h4000,
                                      16'h5555, 16'h1234));
        foreach (dir_q[i])
            send(dir_q[i]);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    sl = 22'h3FFFFF;
                    nstr = 16'hFFFF;
                    bw = 10'd1023;
                    bh = 10'd1023;
                end
                1:
                begin
                    sl = 0;
                    nstr = 0;
                    bw = 10'd1;
                    bh = 10'd1;
                end
                2:
                begin
                    sl = 22'($urandom);
                    nstr = 16'($urandom);
                    bw = 0;
                    bh = 0;
                end
                default:
                begin
                    sl = 22'($urandom);
                    nstr = 16'($urandom);
                    bw = 10'($urandom_range(1, 1023));
                    bh = 10'($urandom_range(1, 1023));
                end
            endcase
            if (ph == 5)
                quiet = 1'b1;
            program_regs(sl, nstr, bw, bh, ph == 3);
            if (ph == 0)
                send(mk(0, 0, 0, 0, 0, 16'h7FFF, 16'hFFFF));
            for (int i = 0; i < RAND_PER_PHASE; i++)
            begin
                if (i == RAND_PER_PHASE / 2)
                    drain();
                send(mk(rand_pos(bw), rand_pos(bh), rand_disp(), rand_disp(),
                        16'($urandom), 16'($urandom), 16'($urandom)));
            end
        end

        drain();
        $display("Covered %0d particle updates over six register settings,", sb.checked);
        $display("including full and empty box sizes, zero and full noise, saturation.");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
